// ===== design/sfd_pkg.sv =====
// Shared types and constants for the SBUS frame decoder.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam logic [7:0]  SYNC_BYTE    = 8'hF0;
  localparam int          FRAME_LEN    = 25;
  localparam logic [4:0]  FRAME_LAST   = 5'(FRAME_LEN - 1);
  localparam logic [4:0]  MAX_CH       = 5'd18;
  localparam logic [4:0]  DIG_FIRST    = 5'd16;
  localparam logic [4:0]  NUM_CH_RESET = 5'd16;
  localparam int          RAW_W        = 11;
  localparam int          BUF_W        = 18;
  localparam logic [10:0] MID_OFFSET   = 11'd988;
  localparam logic [10:0] DIG_HIGH     = 11'd2000;
  localparam logic [10:0] DIG_LOW      = 11'd1000;

  // Register index as decoded from paddr[2].
  localparam logic        REG_NUM_CHANNELS = 1'b0;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_CHECK,
    ST_FETCH,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [BUF_W-1:0] buf_loaded;
    logic [4:0]       cnt_loaded;
    logic [BUF_W-1:0] buf_shifted;
    logic [4:0]       cnt_shifted;
    logic [10:0]      value;
  } unpack_t;

endpackage

// ===== design/sfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/sfd_unpack.sv =====
// Shared shift unit: merges frame bytes into the bit buffer and extracts channel values.
`timescale 1ns / 1ps

module sfd_unpack (
  input  logic [sfd_pkg::BUF_W-1:0] bit_buf,
  input  logic [4:0]                bit_cnt,
  input  logic [7:0]                rd_data,
  input  logic                      dig,
  input  logic                      dig_sel,
  output sfd_pkg::unpack_t          res
);

  logic        dig_bit;
  logic [9:0]  half_raw;

  assign dig_bit  = dig_sel ? bit_buf[1] : bit_buf[0];
  assign half_raw = bit_buf[sfd_pkg::RAW_W-1:1];

  always_comb begin
    // A new byte lands just above the bits still waiting in the buffer.
    res.buf_loaded  = bit_buf | (sfd_pkg::BUF_W'(rd_data) << bit_cnt);
    res.cnt_loaded  = bit_cnt + 5'd8;
    res.buf_shifted = bit_buf >> sfd_pkg::RAW_W;
    res.cnt_shifted = bit_cnt - 5'(sfd_pkg::RAW_W);
    if (dig) begin
      res.value = dig_bit ? sfd_pkg::DIG_HIGH : sfd_pkg::DIG_LOW;
    end else begin
      res.value = {1'b0, half_raw} + sfd_pkg::MID_OFFSET;
    end
  end

endmodule

// ===== design/sbus_frame_decoder_unit.sv =====
// Top level of the SBUS frame decoder: byte collection, decode sequencer and APB register.
`timescale 1ns / 1ps

// Bytes are taken one per cycle while a frame is being collected; bytes other than
// 0xF0 are dropped while no frame is open. When the 25th byte of a frame arrives and
// the run length is not zero, rx_stall rises and the block unpacks the frame from its
// byte store, which has a single read port: each frame byte needed passes through the
// fetch, merge and check steps in the shared shift unit, and each channel word through
// the check and emit steps plus any output stall, holding the input for the whole run.
// The run length is num_channels at byte address 0 (values above 18 act as 18, zero
// emits nothing); last_of_frame marks the final word of each run.
module sbus_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        ch_valid,
  input  logic        ch_stall,
  output logic [4:0]  channel_index,
  output logic [10:0] channel_value,
  output logic        last_of_frame,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sfd_pkg::state_t state, state_next;

  logic [4:0]                byte_position;
  logic [4:0]                num_channels;
  logic [4:0]                run_len;
  logic [4:0]                rd_addr;
  logic [sfd_pkg::BUF_W-1:0] bit_buf;
  logic [4:0]                bit_cnt;
  logic [4:0]                ch_k;
  logic [7:0]                rd_data;
  sfd_pkg::unpack_t          unpack_res;

  logic       cfg_write;
  logic       rx_take;
  logic       frame_store;
  logic       frame_done;
  logic [4:0] n_sat;
  logic       ch_take;
  logic       dig;
  logic       word_ready;
  logic       rd_en;
  logic       load_en;
  logic       emit_en;
  logic       advance_en;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready
                     & (paddr[2] == sfd_pkg::REG_NUM_CHANNELS);
  assign prdata    = (paddr[2] == sfd_pkg::REG_NUM_CHANNELS) ? {27'b0, num_channels} : '0;

  assign rx_stall    = (state != sfd_pkg::ST_COLLECT);
  assign rx_take     = rx_valid & ~rx_stall;
  assign frame_store = rx_take & ((byte_position != 5'd0) | (rx_byte == sfd_pkg::SYNC_BYTE));
  assign frame_done  = frame_store & (byte_position == sfd_pkg::FRAME_LAST);
  assign n_sat       = (num_channels > sfd_pkg::MAX_CH) ? sfd_pkg::MAX_CH : num_channels;
  assign ch_take     = ch_valid & ~ch_stall;

  // The digital channels read byte 23, which is the only byte left in the buffer
  // once all sixteen analog channels have been consumed.
  assign dig        = (ch_k >= sfd_pkg::DIG_FIRST);
  assign word_ready = dig ? (bit_cnt != 5'd0) : (bit_cnt >= 5'(sfd_pkg::RAW_W));

  sfd_ram #(
    .WIDTH (8),
    .DEPTH (sfd_pkg::FRAME_LEN)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (frame_store),
    .wr_addr (byte_position),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sfd_unpack u_unpack (
    .bit_buf (bit_buf),
    .bit_cnt (bit_cnt),
    .rd_data (rd_data),
    .dig     (dig),
    .dig_sel (ch_k[0]),
    .res     (unpack_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfd_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    load_en    = 1'b0;
    emit_en    = 1'b0;
    advance_en = 1'b0;
    case (state)
      sfd_pkg::ST_COLLECT: begin
        if (frame_done && (n_sat != 5'd0)) begin
          state_next = sfd_pkg::ST_CHECK;
        end
      end
      sfd_pkg::ST_CHECK: begin
        if (word_ready) begin
          emit_en    = 1'b1;
          state_next = sfd_pkg::ST_EMIT;
        end else begin
          state_next = sfd_pkg::ST_FETCH;
        end
      end
      sfd_pkg::ST_FETCH: begin
        rd_en      = 1'b1;
        state_next = sfd_pkg::ST_LOAD;
      end
      sfd_pkg::ST_LOAD: begin
        load_en    = 1'b1;
        state_next = sfd_pkg::ST_CHECK;
      end
      sfd_pkg::ST_EMIT: begin
        if (ch_take) begin
          advance_en = 1'b1;
          state_next = last_of_frame ? sfd_pkg::ST_COLLECT : sfd_pkg::ST_CHECK;
        end
      end
      default: begin
        state_next = sfd_pkg::ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 5'd0;
      num_channels  <= sfd_pkg::NUM_CH_RESET;
      ch_valid      <= 1'b0;
      ch_k          <= 5'd0;
      bit_cnt       <= 5'd0;
    end else begin
      if (cfg_write) begin
        num_channels <= pwdata[4:0];
      end
      if (frame_store) begin
        byte_position <= frame_done ? 5'd0 : byte_position + 5'd1;
      end
      if (frame_done) begin
        run_len <= n_sat;
        rd_addr <= 5'd1;
        bit_buf <= '0;
        bit_cnt <= 5'd0;
        ch_k    <= 5'd0;
      end
      if (load_en) begin
        bit_buf <= unpack_res.buf_loaded;
        bit_cnt <= unpack_res.cnt_loaded;
        rd_addr <= rd_addr + 5'd1;
      end
      if (emit_en) begin
        ch_valid      <= 1'b1;
        channel_index <= ch_k;
        channel_value <= unpack_res.value;
        last_of_frame <= (ch_k == run_len - 5'd1);
      end
      if (advance_en) begin
        ch_valid <= 1'b0;
        ch_k     <= ch_k + 5'd1;
        // Digital channels only look at bits of the last byte fetched (byte 23) and consume nothing.
        if (!dig) begin
          bit_buf <= unpack_res.buf_shifted;
          bit_cnt <= unpack_res.cnt_shifted;
        end
      end
    end
  end

  a_valid_in_emit: assert property (@(posedge clk) disable iff (rst)
    ch_valid |-> (state == sfd_pkg::ST_EMIT))
    else $error("channel word valid outside the emit state");

  a_no_input_during_run: assert property (@(posedge clk) disable iff (rst)
    ch_valid |-> rx_stall)
    else $error("input open while a channel word is pending");

  a_buffer_bound: assert property (@(posedge clk) disable iff (rst)
    bit_cnt <= 5'(sfd_pkg::BUF_W))
    else $error("bit buffer count overflow");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (ch_take && last_of_frame) |=> (state == sfd_pkg::ST_COLLECT))
    else $error("run did not end after the last word");

endmodule

// ===== dv/tb_sbus_frame_decoder_unit.sv =====
// Self-checking testbench for the SBUS frame decoder unit.
`timescale 1ns / 1ps

module tb_sbus_frame_decoder_unit;

  localparam logic [2:0] ADDR_NUM_CHANNELS = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
  localparam int         DIG_BYTE          = 23;
  localparam int         SETTLE_CYCLES     = 150;
  localparam int         HOLD_CYCLES       = 300;
  localparam int         LIMIT_CYCLES      = 200000;

  typedef struct packed {
    logic [4:0]  chan;
    logic [10:0] level;
    logic        tail;
  } chan_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        ch_valid;
  logic        ch_stall = 1'b0;
  logic [4:0]  channel_index;
  logic [10:0] channel_value;
  logic        last_of_frame;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  sbus_frame_decoder_unit dut (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .ch_valid(ch_valid), .ch_stall(ch_stall),
    .channel_index(channel_index), .channel_value(channel_value),
    .last_of_frame(last_of_frame),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Decoder shadow state.
  logic [7:0]  frame_buf [0:sfd_pkg::FRAME_LEN-1];
  int          frame_pos = 0;
  logic [4:0]  num_ch_cfg = sfd_pkg::NUM_CH_RESET;

  logic [7:0]  pending_bytes [$];
  chan_word_t  expected_words [$];

  int          error_count = 0;
  int          words_checked = 0;
  int          frames_done = 0;
  int          settings_run = 0;
  logic        quiet = 1'b0;
  logic        hold_arm = 1'b0;
  int          hold_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [10:0] channel_value_of(input int k);
    int          bit_at;
    int          base;
    logic [23:0] span;
    logic [10:0] raw;
    if (k >= sfd_pkg::DIG_FIRST) begin
      return frame_buf[DIG_BYTE][k - sfd_pkg::DIG_FIRST] ? sfd_pkg::DIG_HIGH
                                                          : sfd_pkg::DIG_LOW;
    end
    bit_at = 11 * k;
    base   = 1 + bit_at / 8;
    span   = {frame_buf[base + 2], frame_buf[base + 1], frame_buf[base]};
    raw    = 11'(span >> (bit_at % 8));
    return (raw >> 1) + sfd_pkg::MID_OFFSET;
  endfunction

  task automatic decode_frame_byte(input logic [7:0] b);
    chan_word_t w;
    int         run_len;
    if (frame_pos == 0 && b != sfd_pkg::SYNC_BYTE) return;
    frame_buf[frame_pos] = b;
    frame_pos++;
    if (frame_pos < sfd_pkg::FRAME_LEN) return;
    frame_pos = 0;
    frames_done++;
    run_len = (num_ch_cfg > sfd_pkg::MAX_CH) ? int'(sfd_pkg::MAX_CH) : int'(num_ch_cfg);
    for (int k = 0; k < run_len; k++) begin
      w.chan  = 5'(k);
      w.level = channel_value_of(k);
      w.tail  = (k == run_len - 1);
      expected_words.push_back(w);
    end
  endtask

  // Data bytes lean toward the extremes so raw channels hit 0 and 0x7FF.
  function automatic logic [7:0] random_data_byte();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return 8'h00;
    if (pick < 4) return 8'hFF;
    if (pick == 4) return sfd_pkg::SYNC_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_frame(input logic fixed, input logic [7:0] fill,
                             input logic [7:0] dig_bits);
    pending_bytes.push_back(sfd_pkg::SYNC_BYTE);
    for (int i = 1; i < sfd_pkg::FRAME_LEN; i++) begin
      if (!fixed) pending_bytes.push_back(random_data_byte());
      else if (i == DIG_BYTE) pending_bytes.push_back(dig_bits);
      else pending_bytes.push_back(fill);
    end
  endtask

  task automatic queue_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      b = 8'($urandom_range(0, 255));
      if (b == sfd_pkg::SYNC_BYTE) b = ~b;
      pending_bytes.push_back(b);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (wr && addr == ADDR_NUM_CHANNELS) num_ch_cfg = data[4:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_num_channels();
    logic [31:0] rd;
    apb_access(1'b0, ADDR_NUM_CHANNELS, 32'd0, rd);
    if (rd !== 32'(num_ch_cfg)) begin
      $display("%0t ns: num_channels readback mismatch, expected %0d, got %0d",
               $time, num_ch_cfg, rd);
      error_count++;
    end
  endtask

  task automatic write_num_channels(input logic [4:0] n);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_NUM_CHANNELS, ($urandom() & ~32'h1F) | 32'(n), rd);
    settings_run++;
    check_num_channels();
  endtask

  // Everything sent has been accepted and every expected word has arrived;
  // the block can still be finishing its last word, so let the block settle.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || rx_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: one byte offered at a time, with random gaps between bytes.
  always @(posedge clk) begin : drive_proc
    logic offer;
    if (rst) begin
      rx_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      offer = rx_valid;
      if (rx_valid && !rx_stall) begin
        decode_frame_byte(rx_byte);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_bytes.size() != 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            gap_left <= $urandom_range(0, 4);
          end else begin
            rx_byte <= pending_bytes.pop_front();
            offer = 1'b1;
          end
        end
      end
      rx_valid <= offer;
    end
  end

  // Long output hold-off, counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin : hold_proc
    if (rst) hold_left <= 0;
    else if (hold_arm) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Receiver: check each accepted word against the oldest expectation.
  always @(posedge clk) begin : watch_proc
    chan_word_t want;
    logic       stall_next;
    if (rst) begin
      ch_stall   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (ch_valid && !ch_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, got ch %0d value %0d last %0b",
                   $time, channel_index, channel_value, last_of_frame);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (channel_index !== want.chan) begin
            $display("%0t ns: channel_index mismatch, expected %0d, got %0d",
                     $time, want.chan, channel_index);
            error_count++;
          end
          if (channel_value !== want.level) begin
            $display("%0t ns: channel_value mismatch on ch %0d, expected %0d, got %0d",
                     $time, want.chan, want.level, channel_value);
            error_count++;
          end
          if (last_of_frame !== want.tail) begin
            $display("%0t ns: last_of_frame mismatch on ch %0d, expected %0b, got %0b",
                     $time, want.chan, want.tail, last_of_frame);
            error_count++;
          end
        end
      end
      stall_next = 1'b0;
      if (hold_left > 0) begin
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_next = 1'b1;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        stall_next = 1'b1;
        stall_left <= $urandom_range(0, 4);
      end
      ch_stall <= stall_next;
    end
  end

  initial begin : stimulus_proc
    logic [4:0]  cfg_plan [0:6];
    logic [31:0] rd;
    cfg_plan = '{5'd18, 5'd1, 5'd0, 5'd31, 5'd19, 5'd0, 5'd18};
    cfg_plan[5] = 5'($urandom_range(2, 17));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_num_channels();
    settings_run++;

    // Directed frames under the reset setting, with the output held off early.
    @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(8'h0F);
    queue_frame(1'b1, 8'h00, 8'h01);
    // A sync byte inside an open frame is ordinary data.
    queue_frame(1'b1, sfd_pkg::SYNC_BYTE, 8'h00);
    queue_frame(1'b1, 8'hFF, 8'h02);

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      if (p == 0) begin
        // Writes to an unmapped address must leave num_channels alone.
        apb_access(1'b1, ADDR_UNMAPPED, 32'h0000_0003, rd);
        check_num_channels();
      end
      write_num_channels(cfg_plan[p]);
      if (p == 6) quiet = 1'b1;
      if ($urandom_range(0, 2) == 0) queue_noise($urandom_range(1, 6));
      queue_frame(1'b0, 8'h00, 8'h00);
    end

    wait_idle();
    if (expected_words.size() != 0) begin
      $display("%0t ns: %0d expected words never arrived", $time, expected_words.size());
      error_count++;
    end
    $display("Run covered %0d frames and %0d channel words over %0d num_channels settings,",
             frames_done, words_checked, settings_run);
    $display("including empty, single-word, full and saturated runs and a long output hold-off.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
